// ===== hw/rtl/sorted_priority_queue_macros.svh =====
// Assertion macros used by the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("queue invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue same-cycle check failed");

`endif

// ===== hw/rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int CAPACITY     = 64;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } spq_entry_t;

  // Broadcast to every cell of the chain in the cycle a transaction is taken.
  typedef struct packed {
    logic       insert;
    logic       remove;
    spq_entry_t item;
  } spq_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire spq_cmd_t   cmd,
  input  wire logic       occupied,
  input  wire logic       left_less,
  input  wire spq_entry_t left_entry,
  input  wire spq_entry_t right_entry,
  output spq_entry_t      entry,
  output logic            less
);

  spq_entry_t entry_next;

  // A stored entry strictly smaller than the new key stays in place; an equal
  // key is pushed right so the new entry is served first.
  assign less = occupied && (entry.key < cmd.item.key);

  always_comb begin
    entry_next = entry;
    if (cmd.insert && !less) begin
      if (left_less) begin
        entry_next = cmd.item;
      end else begin
        entry_next = left_entry;
      end
    end else if (cmd.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue.sv =====
// Channel   Handshake             Fields
// input     in_valid / in_ready   operation, key, payload
// result    res_valid / res_ready out_valid, out_key, out_payload, status, count
//
// One transaction per clock while results are taken: every cell compares its key
// with the new key in parallel and shifts one place, and the result appears in
// the output register in the next cycle.
// Reset empties the queue (fill count zero) and clears the result valid flags;
// result fields and cell storage are not reset; unused storage is never read out.
// A result that is not taken holds the output register and stalls the input.
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              operation,
  input  wire logic [KEY_BITS-1:0]     key,
  input  wire logic [PAYLOAD_BITS-1:0] payload,
  output logic                         res_valid,
  input  wire logic                    res_ready,
  output logic                         out_valid,
  output logic [KEY_BITS-1:0]          out_key,
  output logic [PAYLOAD_BITS-1:0]      out_payload,
  output logic [1:0]                   status,
  output logic [COUNT_BITS-1:0]        count
);

  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  logic [COUNT_BITS-1:0]   fill;
  logic [COUNT_BITS-1:0]   fill_next;
  logic                    out_valid_next;
  logic [KEY_BITS-1:0]     out_key_next;
  logic [PAYLOAD_BITS-1:0] out_payload_next;
  status_t                 status_next;
  spq_cmd_t                cmd;
  spq_entry_t              entries [CAPACITY];
  logic                    less    [CAPACITY];

  assign in_ready = !res_valid || res_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (fill == COUNT_BITS'(CAPACITY));
  assign is_empty = (fill == '0);
  assign count    = fill;

  always_comb begin
    cmd.insert       = 1'b0;
    cmd.remove       = 1'b0;
    cmd.item.key     = key;
    cmd.item.payload = payload;
    fill_next        = fill;
    out_valid_next   = 1'b0;
    out_key_next     = '0;
    out_payload_next = '0;
    status_next      = STATUS_OK;
    if (accept) begin
      case (operation)
        OP_INSERT: begin
          if (is_full) begin
            status_next = STATUS_FULL;
          end else begin
            cmd.insert = 1'b1;
            fill_next  = fill + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (is_empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            cmd.remove       = 1'b1;
            fill_next        = fill - 1'b1;
            out_valid_next   = 1'b1;
            out_key_next     = entries[0].key;
            out_payload_next = entries[0].payload;
          end
        end
        OP_CLEAR: begin
          fill_next = '0;
        end
        default: begin
          // The unused code leaves the queue as it is.
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       left_less;
    spq_entry_t left_entry;
    spq_entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_less  = 1'b1;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_less  = less[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (COUNT_BITS'(i) < fill),
      .left_less   (left_less),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .less        (less[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        res_valid <= 1'b1;
        out_valid <= out_valid_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_key     <= out_key_next;
      out_payload <= out_payload_next;
      status      <= status_next;
    end
  end

  `SPQ_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= COUNT_BITS'(CAPACITY))
  `SPQ_ASSERT_SAME(a_out_valid_framed, clk, rst, out_valid, res_valid)
  `SPQ_ASSERT_NEXT(a_remove_count, clk, rst, accept && operation == OP_REMOVE && !is_empty, out_valid && fill == $past(fill) - 1'b1)
  `SPQ_ASSERT_NEXT(a_full_drop, clk, rst, accept && operation == OP_INSERT && is_full, status == STATUS_FULL && $stable(fill))

endmodule

`default_nettype wire

// ===== tb/tb_sorted_priority_queue.sv =====
`default_nettype none

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int LONG_HOLD    = 300;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};
  localparam logic [PAYLOAD_BITS-1:0] PAYLOAD_MAX = {PAYLOAD_BITS{1'b1}};

  typedef struct packed {
    logic                    valid;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [1:0]              status;
    logic [COUNT_BITS-1:0]   count;
  } pq_result_t;

  // Keeps a sorted copy of the queue and the results still owed by the block.
  class pq_scoreboard;
    spq_entry_t stored[$];
    pq_result_t owed[$];
    int errors;
    int checked;
    int served;
    int empty_hits;
    int full_drops;
    int clears;

    function void note_input(logic [1:0] op, logic [KEY_BITS-1:0] k,
                             logic [PAYLOAD_BITS-1:0] p);
      pq_result_t r;
      spq_entry_t e;
      int pos;
      r = '0;
      r.status = STATUS_OK;
      e.key = k;
      e.payload = p;
      case (op)
        OP_INSERT: begin
          if (stored.size() >= CAPACITY) begin
            r.status = STATUS_FULL;
            full_drops++;
          end else begin
            // A new entry goes ahead of any stored entry with the same key.
            pos = 0;
            while (pos < stored.size() && stored[pos].key < k) pos++;
            stored.insert(pos, e);
          end
        end
        OP_REMOVE: begin
          if (stored.size() == 0) begin
            r.status = STATUS_EMPTY;
            empty_hits++;
          end else begin
            e = stored.pop_front();
            r.valid = 1'b1;
            r.key = e.key;
            r.payload = e.payload;
            served++;
          end
        end
        OP_CLEAR: begin
          stored.delete();
          clears++;
        end
        default: ;
      endcase
      r.count = COUNT_BITS'(stored.size());
      owed.push_back(r);
    endfunction

    function void report_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(pq_result_t got);
      pq_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result transaction with none outstanding, actual %h", $time, got);
        return;
      end
      want = owed.pop_front();
      checked++;
      report_field("out_valid", 64'(want.valid), 64'(got.valid));
      report_field("out_key", 64'(want.key), 64'(got.key));
      report_field("out_payload", 64'(want.payload), 64'(got.payload));
      report_field("status", 64'(want.status), 64'(got.status));
      report_field("count", 64'(want.count), 64'(got.count));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              operation = OP_INSERT;
  logic [KEY_BITS-1:0]     key = '0;
  logic [PAYLOAD_BITS-1:0] payload = '0;
  logic                    res_valid;
  logic                    res_ready = 1'b0;
  logic                    out_valid;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [1:0]              status;
  logic [COUNT_BITS-1:0]   count;

  pq_scoreboard sb = new();
  int items_sent = 0;
  int cycles = 0;

  sorted_priority_queue dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .key        (key),
    .payload    (payload),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .out_valid  (out_valid),
    .out_key    (out_key),
    .out_payload(out_payload),
    .status     (status),
    .count      (count)
  );

  always #2 clk = ~clk;

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_gap(bit quiet);
    if (quiet || $urandom_range(0, 99) < 60) return 0;
    return pick_gap();
  endfunction

  function automatic logic [KEY_BITS-1:0] rand_key(int mode);
    case (mode)
      0: return KEY_BITS'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return KEY_BITS'(1);
          2: return KEY_MAX - 1'b1;
          3: return KEY_MAX;
          default: return {1'b1, {(KEY_BITS-1){1'b0}}};
        endcase
      end
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  task automatic send(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
                      input logic [PAYLOAD_BITS-1:0] p, input int gap);
    @(negedge clk);
    in_valid = 1'b1;
    operation = op;
    key = k;
    payload = p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, k, p);
    items_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    // Nothing may stay offered while the sender waits.
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic send_mixed(int n, int kmode, bit quiet);
    int r;
    logic [1:0] op;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 48) op = OP_INSERT;
      else if (r < 90) op = OP_REMOVE;
      else if (r < 95) op = OP_CLEAR;
      else op = OP_UNUSED;
      send(op, rand_key(kmode), PAYLOAD_BITS'($urandom), next_gap(quiet));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      sb.check_result({out_valid, out_key, out_payload, status, count});
    end
  end

  initial begin : result_side
    int stall;
    int free_run;
    bit hold_done;
    stall = 0;
    free_run = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      // One long hold-off lets the input back up while the sender keeps offering.
      if (!hold_done && sb.checked >= 400) begin
        hold_done = 1'b1;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        res_ready = 1'b0;
        stall--;
      end else if (free_run > 0) begin
        res_ready = 1'b1;
        free_run--;
      end else if ($urandom_range(0, 99) < 5) begin
        res_ready = 1'b1;
        free_run = $urandom_range(50, 150);
      end else if ($urandom_range(0, 99) < 70) begin
        res_ready = 1'b1;
      end else begin
        res_ready = 1'b0;
        stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int kind;
    int kmode;
    int n;
    int stop_at;
    bit quiet;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty queue: remove error and the unused code.
    send(OP_REMOVE, KEY_MAX, PAYLOAD_MAX, 0);
    send(OP_UNUSED, '0, '0, 1);
    // Extremes, then two equal keys: the later one must come out first.
    send(OP_INSERT, KEY_MAX, PAYLOAD_MAX, 0);
    send(OP_INSERT, '0, '0, 0);
    send(OP_INSERT, KEY_BITS'(5), PAYLOAD_BITS'(32'h0000_00a1), 2);
    send(OP_INSERT, KEY_BITS'(5), PAYLOAD_BITS'(32'h0000_00b2), 0);
    repeat (4) send(OP_REMOVE, '0, '0, 0);
    send(OP_REMOVE, '0, '0, 3);
    send(OP_INSERT, KEY_BITS'(7), PAYLOAD_BITS'(32'h5555_5555), 0);
    send(OP_INSERT, KEY_BITS'(3), PAYLOAD_BITS'(32'haaaa_aaaa), 0);
    send(OP_UNUSED, KEY_MAX, PAYLOAD_MAX, 0);
    send(OP_CLEAR, KEY_MAX, PAYLOAD_MAX, 0);
    send(OP_REMOVE, '0, '0, 0);
    send(OP_INSERT, {1'b1, {(KEY_BITS-1){1'b0}}}, PAYLOAD_BITS'(1), 0);
    send(OP_INSERT, {1'b0, {(KEY_BITS-1){1'b1}}}, PAYLOAD_MAX - 1'b1, 0);
    send(OP_REMOVE, '0, '0, 0);
    send(OP_CLEAR, '0, '0, 0);
    // Sender holds back until everything owed has arrived.
    wait_drained();

    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      kmode = $urandom_range(0, 3);
      quiet = ($urandom_range(0, 3) == 0);
      case (kind)
        0, 1, 2: begin
          // Fill past capacity so the last inserts are dropped.
          n = CAPACITY - sb.stored.size() + $urandom_range(1, 3);
          repeat (n) begin
            send(OP_INSERT, rand_key(kmode), PAYLOAD_BITS'($urandom), next_gap(quiet));
          end
        end
        3, 4: begin
          n = sb.stored.size() + $urandom_range(1, 2);
          repeat (n) begin
            send(OP_REMOVE, rand_key(2), PAYLOAD_BITS'($urandom), next_gap(quiet));
          end
        end
        9: begin
          wait_drained();
          send_mixed($urandom_range(20, 40), kmode, quiet);
        end
        default: send_mixed($urandom_range(20, 40), kmode, quiet);
      endcase
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results in %0d cycles.",
             items_sent, sb.checked, cycles);
    $display("Served %0d entries, %0d removes on empty, %0d inserts dropped full, %0d clears.",
             sb.served, sb.empty_hits, sb.full_drops, sb.clears);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
